FILE: src/ica_pkg.sv
// ----------------------------------------------------------------------------
// ica_pkg
// Opcodes, pipeline stage type and divider step for the 64-bit integer ALU.
// ----------------------------------------------------------------------------
package ica_pkg;

  localparam int unsigned DATA_W    = 64;
  localparam int unsigned HALF_W    = DATA_W / 2;
  localparam int unsigned SHAMT_W   = $clog2(DATA_W);
  localparam int unsigned DIV_STEPS = DATA_W;

  typedef enum logic [4:0] {
    OP_ADD  = 5'd0,
    OP_SUB  = 5'd1,
    OP_MUL  = 5'd2,
    OP_DIV  = 5'd3,
    OP_MOD  = 5'd4,
    OP_SHL  = 5'd5,
    OP_SHR  = 5'd6,
    OP_AND  = 5'd7,
    OP_OR   = 5'd8,
    OP_XOR  = 5'd9,
    OP_LAND = 5'd10,
    OP_LOR  = 5'd11,
    OP_EQ   = 5'd12,
    OP_NE   = 5'd13,
    OP_GT   = 5'd14,
    OP_GE   = 5'd15,
    OP_LT   = 5'd16,
    OP_LE   = 5'd17
  } op_t;

  typedef struct packed {
    logic              is_div;
    logic              is_mod;
    logic              qneg;
    logic              rneg;
    logic              dz;
    logic              bad;
    logic [DATA_W-1:0] res;
    logic [DATA_W-1:0] rem;
    logic [DATA_W-1:0] quo;
    logic [DATA_W-1:0] dvs;
  } stage_t;

  // one restoring division step: shift in the next dividend bit, try subtract
  function automatic stage_t div_step(stage_t s);
    stage_t        o;
    logic [DATA_W:0] t;
    logic [DATA_W:0] diff;
    o    = s;
    t    = {s.rem, s.quo[DATA_W-1]};
    diff = t - {1'b0, s.dvs};
    if (!diff[DATA_W]) begin
      o.rem = diff[DATA_W-1:0];
      o.quo = {s.quo[DATA_W-2:0], 1'b1};
    end else begin
      o.rem = t[DATA_W-1:0];
      o.quo = {s.quo[DATA_W-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage

FILE: src/integer_constant_alu_core.sv
// ----------------------------------------------------------------------------
// integer_constant_alu_core
// Pipelined 64-bit integer ALU with a one-bit-per-stage divider.
// Stages from input accept to out_valid: input, operate, multiply sum,
//   64 divider stages, output register; every op passes through all of them.
// Throughput: one item per cycle; a stall at the output freezes every stage.
// Reset: rst_n clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
module integer_constant_alu_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [4:0]  in_func,
  input  logic        in_sign_mode,
  input  logic [63:0] in_left_operand,
  input  logic [63:0] in_right_operand,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_value,
  output logic        out_bad_op
);

  localparam int unsigned W  = ica_pkg::DATA_W;
  localparam int unsigned HW = ica_pkg::HALF_W;
  localparam int unsigned SW = ica_pkg::SHAMT_W;
  localparam int unsigned NS = ica_pkg::DIV_STEPS;

  logic en;

  // input stage
  logic         a_vld_r;
  logic [4:0]   a_func_r;
  logic         a_sgn_r;
  logic [W-1:0] a_l_r;
  logic [W-1:0] a_rt_r;

  // operate stage
  logic         b_vld_r;
  logic         b_is_mul_r;
  logic [W-1:0] b_pp0_r;
  logic [HW-1:0] b_pp1_r;
  logic [HW-1:0] b_pp2_r;
  ica_pkg::stage_t b_st_r;
  ica_pkg::stage_t b_st_nxt;

  // multiply sum stage and divider stages
  logic [NS:0]     d_vld_r;
  ica_pkg::stage_t d_st_r [0:NS];
  ica_pkg::stage_t d_st0_nxt;

  logic         out_valid_r;
  logic [W-1:0] out_value_r;
  logic         out_bad_op_r;
  logic [W-1:0] out_value_nxt;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_func_r <= in_func;
      a_sgn_r  <= in_sign_mode;
      a_l_r    <= in_left_operand;
      a_rt_r   <= in_right_operand;
    end
  end

  logic         big_sh;
  logic [SW-1:0] sh;
  logic         lt_ab;
  logic         lt_ba;
  logic         an;
  logic         bn;
  logic [W-1:0] ua;
  logic [W-1:0] ub;
  logic [W-1:0] sra;

  always_comb begin
    big_sh = |a_rt_r[W-1:SW];
    sh     = a_rt_r[SW-1:0];
    lt_ab  = a_sgn_r ? ($signed(a_l_r) < $signed(a_rt_r)) : (a_l_r < a_rt_r);
    lt_ba  = a_sgn_r ? ($signed(a_rt_r) < $signed(a_l_r)) : (a_rt_r < a_l_r);
    an     = a_sgn_r && a_l_r[W-1];
    bn     = a_sgn_r && a_rt_r[W-1];
    ua     = an ? (W'(0) - a_l_r) : a_l_r;
    ub     = bn ? (W'(0) - a_rt_r) : a_rt_r;
    sra    = W'($signed(a_l_r) >>> sh);

    b_st_nxt        = '0;
    b_st_nxt.qneg   = an ^ bn;
    b_st_nxt.rneg   = an;
    b_st_nxt.dz     = (ub == '0);
    b_st_nxt.quo    = ua;
    b_st_nxt.dvs    = ub;
    case (ica_pkg::op_t'(a_func_r))
      ica_pkg::OP_ADD:  b_st_nxt.res = a_l_r + a_rt_r;
      ica_pkg::OP_SUB:  b_st_nxt.res = a_l_r - a_rt_r;
      ica_pkg::OP_MUL:  b_st_nxt.res = '0;
      ica_pkg::OP_DIV:  b_st_nxt.is_div = 1'b1;
      ica_pkg::OP_MOD:  b_st_nxt.is_mod = 1'b1;
      ica_pkg::OP_SHL:  b_st_nxt.res = big_sh ? '0 : (a_l_r << sh);
      ica_pkg::OP_SHR: begin
        if (a_sgn_r) begin
          b_st_nxt.res = big_sh ? {W{a_l_r[W-1]}} : sra;
        end else begin
          b_st_nxt.res = big_sh ? '0 : (a_l_r >> sh);
        end
      end
      ica_pkg::OP_AND:  b_st_nxt.res = a_l_r & a_rt_r;
      ica_pkg::OP_OR:   b_st_nxt.res = a_l_r | a_rt_r;
      ica_pkg::OP_XOR:  b_st_nxt.res = a_l_r ^ a_rt_r;
      ica_pkg::OP_LAND: b_st_nxt.res = W'((a_l_r != '0) && (a_rt_r != '0));
      ica_pkg::OP_LOR:  b_st_nxt.res = W'((a_l_r != '0) || (a_rt_r != '0));
      ica_pkg::OP_EQ:   b_st_nxt.res = W'(a_l_r == a_rt_r);
      ica_pkg::OP_NE:   b_st_nxt.res = W'(a_l_r != a_rt_r);
      ica_pkg::OP_GT:   b_st_nxt.res = W'(lt_ba);
      ica_pkg::OP_GE:   b_st_nxt.res = W'(!lt_ab);
      ica_pkg::OP_LT:   b_st_nxt.res = W'(lt_ab);
      ica_pkg::OP_LE:   b_st_nxt.res = W'(!lt_ba);
      default:          b_st_nxt.bad = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (en) begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_st_r     <= b_st_nxt;
      b_is_mul_r <= (ica_pkg::op_t'(a_func_r) == ica_pkg::OP_MUL);
      b_pp0_r    <= a_l_r[HW-1:0] * a_rt_r[HW-1:0];
      b_pp1_r    <= HW'(a_l_r[HW-1:0] * a_rt_r[W-1:HW]);
      b_pp2_r    <= HW'(a_l_r[W-1:HW] * a_rt_r[HW-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= '0;
    end else if (en) begin
      d_vld_r <= {d_vld_r[NS-1:0], b_vld_r};
    end
  end

  always_comb begin
    d_st0_nxt = b_st_r;
    if (b_is_mul_r) begin
      d_st0_nxt.res = b_pp0_r + {b_pp1_r + b_pp2_r, {HW{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_st_r[0] <= d_st0_nxt;
    end
  end

  for (genvar k = 1; k <= NS; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (en) begin
        d_st_r[k] <= ica_pkg::div_step(d_st_r[k-1]);
      end
    end
  end

  always_comb begin
    out_value_nxt = d_st_r[NS].res;
    if (d_st_r[NS].is_div) begin
      out_value_nxt = d_st_r[NS].dz ? '0 :
                      (d_st_r[NS].qneg ? (W'(0) - d_st_r[NS].quo) : d_st_r[NS].quo);
    end else if (d_st_r[NS].is_mod) begin
      out_value_nxt = d_st_r[NS].dz ? '0 :
                      (d_st_r[NS].rneg ? (W'(0) - d_st_r[NS].rem) : d_st_r[NS].rem);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= d_vld_r[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_value_r  <= out_value_nxt;
      out_bad_op_r <= d_st_r[NS].bad;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_bad_op = out_bad_op_r;

endmodule
